// ===== rtl/core/mmpn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mmpn_pkg;

  // Fraction bits of the Q1.FRAC_BITS result
  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(FRAC_BITS + 1);
  localparam int PIX_W     = 8;

  localparam logic [OUT_W-1:0] ONE_VAL = OUT_W'(1) << FRAC_BITS;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // Register codes
  localparam logic MODE_GLOBAL = 1'b0;
  localparam logic MODE_MINMAX = 1'b1;
  localparam logic OP_STATS    = 1'b0;
  localparam logic OP_EMIT     = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             opcode;
    logic             frame_start;
    logic             frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] norm_value;
    logic             equal_intensity;
    logic             last_out;
  } norm_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } norm_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/minmax_pixel_normalizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Min-max pixel normalizer: 8-bit gray pixels to unsigned Q1.16.
// Input channel in_valid_i/in_ready_o carries one pixel beat (pixel,
// opcode, frame_start, frame_end); output channel out_valid_o/out_ready_i
// carries one result beat (norm_value, equal_intensity, last_out).
// cfg_we_i writes norm_mode from cfg_wdata_i; write it only while idle.
// Global mode: every pixel gives floor(p*65536/255). Min-max mode: a
// statistics pass (opcode 0) updates min and max and gives no beat; an
// emit pass (opcode 1) gives (p-min)*65536/(max-min), clamped.
// Each emitting pixel runs through a restoring divider that shifts out
// one quotient bit per cycle, FRAC_BITS bits in all, and then loads the
// output register; no new pixel is taken while one is in the divider.
// The output register holds a finished beat while the receiver stalls;
// the divider then waits with its result and the input stays blocked
// until the output register frees up.
// Reset clears mode to global, min to 255, max to 0, and empties the
// output register.
module minmax_pixel_normalizer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mmpn_pkg::pix_in_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mmpn_pkg::norm_out_t     out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i
);

  mmpn_pkg::norm_state_e state_q, state_d;

  logic                           mode_q;
  logic [mmpn_pkg::PIX_W-1:0]     min_q, min_d;
  logic [mmpn_pkg::PIX_W-1:0]     max_q, max_d;
  logic [mmpn_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [mmpn_pkg::PIX_W-1:0]     rem_q, rem_d;
  logic [mmpn_pkg::PIX_W-1:0]     div_q, div_d;
  logic [mmpn_pkg::FRAC_BITS-1:0] quo_q, quo_d;
  logic                           sat_q, sat_d;
  logic                           eq_q, eq_d;
  logic                           last_q, last_d;
  logic                           ovalid_q, ovalid_d;
  mmpn_pkg::norm_out_t            odata_q, odata_d;

  logic                           in_beat;
  logic                           is_stats;
  logic                           out_free;
  logic [mmpn_pkg::PIX_W-1:0]     num;
  logic [mmpn_pkg::PIX_W-1:0]     den;
  logic [mmpn_pkg::PIX_W:0]       rem2;
  logic                           qbit;

  assign in_ready_o  = (state_q == mmpn_pkg::ST_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign is_stats    = (mode_q == mmpn_pkg::MODE_MINMAX) &&
                       (in_data_i.opcode == mmpn_pkg::OP_STATS);
  assign out_free    = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  // Divider step: shift remainder, subtract divisor when it fits
  assign rem2 = {rem_q, 1'b0};
  assign qbit = (rem2 >= {1'b0, div_q});

  // Pick numerator and divisor for the accepted pixel
  always_comb begin
    if (mode_q == mmpn_pkg::MODE_GLOBAL) begin
      num = in_data_i.pixel;
      den = mmpn_pkg::PIX_MAX;
    end else begin
      num = (in_data_i.pixel < min_q) ? '0 : in_data_i.pixel - min_q;
      den = (max_q > min_q) ? max_q - min_q : mmpn_pkg::PIX_W'(1);
    end
  end

  // Next state, statistics and divider control
  always_comb begin
    state_d  = state_q;
    min_d    = min_q;
    max_d    = max_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    div_d    = div_q;
    quo_d    = quo_q;
    sat_d    = sat_q;
    eq_d     = eq_q;
    last_d   = last_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odata_d  = odata_q;
    case (state_q)
      mmpn_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (is_stats) begin
            if (in_data_i.frame_start) begin
              min_d = in_data_i.pixel;
              max_d = in_data_i.pixel;
            end else begin
              if (in_data_i.pixel < min_q) min_d = in_data_i.pixel;
              if (in_data_i.pixel > max_q) max_d = in_data_i.pixel;
            end
          end else begin
            // Numerator at or above divisor always lands on 1.0 after clamp
            sat_d   = (num >= den);
            rem_d   = (num >= den) ? '0 : num;
            div_d   = den;
            quo_d   = '0;
            cnt_d   = '0;
            eq_d    = (mode_q == mmpn_pkg::MODE_MINMAX) && (min_q == max_q);
            last_d  = in_data_i.frame_end;
            state_d = mmpn_pkg::ST_DIV;
          end
        end
      end
      mmpn_pkg::ST_DIV: begin
        if (cnt_q != mmpn_pkg::CNT_W'(mmpn_pkg::FRAC_BITS)) begin
          rem_d = qbit ? mmpn_pkg::PIX_W'(rem2 - {1'b0, div_q})
                       : rem2[mmpn_pkg::PIX_W-1:0];
          quo_d = {quo_q[mmpn_pkg::FRAC_BITS-2:0], qbit};
          cnt_d = cnt_q + mmpn_pkg::CNT_W'(1);
        end else if (out_free) begin
          // Hand the finished quotient to the output register
          ovalid_d                = 1'b1;
          odata_d.norm_value      = sat_q ? mmpn_pkg::ONE_VAL : {1'b0, quo_q};
          odata_d.equal_intensity = eq_q;
          odata_d.last_out        = last_q;
          state_d                 = mmpn_pkg::ST_IDLE;
        end
      end
      default: state_d = mmpn_pkg::ST_IDLE;
    endcase
  end

  // Control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mmpn_pkg::ST_IDLE;
      mode_q   <= mmpn_pkg::MODE_GLOBAL;
      min_q    <= mmpn_pkg::PIX_MAX;
      max_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      min_q    <= min_d;
      max_q    <= max_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    div_q   <= div_d;
    quo_q   <= quo_d;
    sat_q   <= sat_d;
    eq_q    <= eq_d;
    last_q  <= last_d;
    odata_q <= odata_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/mmpn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmpn_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire mmpn_pkg::norm_out_t out_data_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Keep the payload of a stalled result beat unchanged
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Clamp never lets the value exceed 1.0
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.norm_value <= mmpn_pkg::ONE_VAL)
    else $error("norm_value above 1.0");

  // Flat frame gives only 0 or 1.0
  a_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.equal_intensity |->
      out_data_o.norm_value == '0 || out_data_o.norm_value == mmpn_pkg::ONE_VAL)
    else $error("flat frame gave fractional value");

endmodule

bind minmax_pixel_normalizer mmpn_checker u_mmpn_checker (.*);

`default_nettype wire

// ===== sim/minmax_pixel_normalizer_test.sv =====
`timescale 1ns / 1ps

module minmax_pixel_normalizer_test;
  import mmpn_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 24;
  localparam int STALL_LIMIT  = 3000;
  localparam int ITEM_TARGET  = 1800;

  // Tracks mode and frame statistics, and holds the normalized beats still due
  class norm_tracker;
    logic           mode;
    logic [PIX_W-1:0] frame_lo;
    logic [PIX_W-1:0] frame_hi;
    norm_out_t      due_beats[$];
    int             errors;

    function new();
      mode     = MODE_GLOBAL;
      frame_lo = PIX_MAX;
      frame_hi = '0;
      errors   = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_one(logic [31:0] v);
      return (v > 32'(ONE_VAL)) ? ONE_VAL : v[OUT_W-1:0];
    endfunction

    // Update statistics or queue the expected beat for one accepted pixel
    function void note_pixel(pix_in_t px);
      norm_out_t   exp_beat;
      logic [31:0] span;
      logic [31:0] num;
      exp_beat = '0;
      exp_beat.last_out = px.frame_end;
      if (mode == MODE_GLOBAL) begin
        num = 32'(px.pixel) << FRAC_BITS;
        exp_beat.norm_value = clamp_one(num / 32'd255);
        due_beats.push_back(exp_beat);
      end else if (px.opcode == OP_STATS) begin
        if (px.frame_start) begin
          frame_lo = px.pixel;
          frame_hi = px.pixel;
        end else begin
          if (px.pixel < frame_lo) frame_lo = px.pixel;
          if (px.pixel > frame_hi) frame_hi = px.pixel;
        end
      end else begin
        span = (frame_hi > frame_lo) ? 32'(frame_hi - frame_lo) : 32'd1;
        exp_beat.equal_intensity = (frame_lo == frame_hi);
        if (px.pixel < frame_lo) begin
          exp_beat.norm_value = '0;
        end else begin
          num = 32'(px.pixel - frame_lo) << FRAC_BITS;
          exp_beat.norm_value = clamp_one(num / span);
        end
        due_beats.push_back(exp_beat);
      end
    endfunction

    // Compare one output beat with the oldest expected beat
    function void check_beat(norm_out_t got);
      norm_out_t want;
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual value %0d eq %0b last %0b",
                 $time, got.norm_value, got.equal_intensity, got.last_out);
        errors++;
        return;
      end
      want = due_beats.pop_front();
      if (got.norm_value !== want.norm_value) begin
        $display("%0t: norm_value expected %0d actual %0d",
                 $time, want.norm_value, got.norm_value);
        errors++;
      end
      if (got.equal_intensity !== want.equal_intensity) begin
        $display("%0t: equal_intensity expected %0b actual %0b",
                 $time, want.equal_intensity, got.equal_intensity);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $display("%0t: last_out expected %0b actual %0b",
                 $time, want.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  pix_in_t   in_data;
  logic      out_valid;
  logic      out_ready;
  norm_out_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;

  norm_tracker tracker;
  int  pixels_sent;
  bit  quiet;
  bit  hold_req;
  int  hold_left;
  int  stall_cycles;

  minmax_pixel_normalizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (quiet) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(0, 99) >= 33);
    end
  end

  // Check every output beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      tracker.check_beat(out_data);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("minmax_pixel_normalizer: mismatch");
        $finish;
      end
    end
  end

  // Offer one pixel beat and hold it until accepted
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic op,
                            input logic start, input logic last);
    while (!quiet && $urandom_range(0, 99) < 33) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data.pixel       = pix;
    in_data.opcode      = op;
    in_data.frame_start = start;
    in_data.frame_end   = last;
    do @(posedge clk_i); while (!in_ready);
    tracker.note_pixel(in_data);
    pixels_sent++;
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  // Wait until every expected beat has come out, then let the block settle
  task automatic drain_outputs();
    while (tracker.due_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain_outputs();
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    tracker.set_mode(m);
  endtask

  task automatic run_global(input int count);
    logic [PIX_W-1:0] pix;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       pix = '0;
        1:       pix = PIX_MAX;
        default: pix = 8'($urandom_range(0, 255));
      endcase
      send_pixel(pix, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // Stream frames twice: statistics pass then emit pass, with some broken frames
  task automatic run_frames(input int frames);
    logic [PIX_W-1:0] pix_list[$];
    logic [PIX_W-1:0] pix;
    int len;
    int kind;
    int base;
    int spread;
    for (int f = 0; f < frames; f++) begin
      len  = $urandom_range(1, 10);
      kind = $urandom_range(0, 9);
      base = $urandom_range(0, 255);
      case ($urandom_range(0, 3))
        0:       spread = 0;
        1:       spread = $urandom_range(1, 8);
        2:       spread = $urandom_range(8, 64);
        default: spread = 255;
      endcase
      pix_list.delete();
      for (int i = 0; i < len; i++) begin
        if (spread == 255) pix = 8'($urandom_range(0, 255));
        else pix = 8'((base + $urandom_range(0, spread)) % 256);
        pix_list.push_back(pix);
      end
      // statistics pass; kind 0 skips the frame start, kind 1 skips the pass
      if (kind != 1) begin
        for (int i = 0; i < len; i++) begin
          send_pixel(pix_list[i], OP_STATS, (kind != 0) && (i == 0), i == len - 1);
        end
      end
      // emit pass, now and then with pixels outside the frame range
      for (int i = 0; i < len; i++) begin
        pix = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : pix_list[i];
        send_pixel(pix, OP_EMIT, 1'($urandom_range(0, 1)), i == len - 1);
      end
      // kind 2 adds a few loose beats of any opcode
      if (kind == 2) begin
        for (int i = 0; i < 3; i++) begin
          send_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    int phase;
    tracker      = new();
    pixels_sent  = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    hold_left    = 0;
    stall_cycles = 0;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Global mode from reset: extremes, control bits ignored
    send_pixel(8'd0,   OP_STATS, 1'b1, 1'b0);
    send_pixel(8'd1,   OP_EMIT,  1'b0, 1'b1);
    send_pixel(8'd127, OP_EMIT,  1'b1, 1'b0);
    send_pixel(8'd128, OP_STATS, 1'b0, 1'b1);
    send_pixel(8'd254, OP_EMIT,  1'b1, 1'b1);
    send_pixel(8'd255, OP_STATS, 1'b0, 1'b0);

    // Min-max mode: emit before any statistics
    write_mode(MODE_MINMAX);
    send_pixel(8'd0,   OP_EMIT, 1'b0, 1'b0);
    send_pixel(8'd255, OP_EMIT, 1'b1, 1'b1);

    // Pixels below the minimum and above the maximum clamp
    send_pixel(8'd100, OP_STATS, 1'b1, 1'b0);
    send_pixel(8'd150, OP_STATS, 1'b0, 1'b1);
    send_pixel(8'd99,  OP_EMIT,  1'b0, 1'b0);
    send_pixel(8'd151, OP_EMIT,  1'b0, 1'b0);
    send_pixel(8'd125, OP_EMIT,  1'b0, 1'b1);

    // Equal intensity frame
    send_pixel(8'd77, OP_STATS, 1'b1, 1'b0);
    send_pixel(8'd77, OP_STATS, 1'b0, 1'b1);
    send_pixel(8'd77, OP_EMIT,  1'b0, 1'b0);
    send_pixel(8'd78, OP_EMIT,  1'b0, 1'b0);
    send_pixel(8'd76, OP_EMIT,  1'b0, 1'b1);

    // Full range frame
    send_pixel(8'd0,   OP_STATS, 1'b1, 1'b0);
    send_pixel(8'd255, OP_STATS, 1'b0, 1'b1);
    send_pixel(8'd0,   OP_EMIT,  1'b0, 1'b0);
    send_pixel(8'd1,   OP_EMIT,  1'b1, 1'b0);
    send_pixel(8'd255, OP_EMIT,  1'b0, 1'b1);

    // Random phases, alternating modes
    phase = 0;
    while (pixels_sent < ITEM_TARGET) begin
      phase++;
      quiet = (phase == 4);
      if (phase % 2 == 0) begin
        write_mode(MODE_GLOBAL);
        if (phase == 2) hold_req = 1'b1;
        run_global($urandom_range(40, 120));
      end else begin
        write_mode(MODE_MINMAX);
        if (phase == 5) hold_req = 1'b1;
        run_frames($urandom_range(5, 15));
      end
    end
    quiet = 1'b0;

    // Let the last beats out, then report
    drain_outputs();
    repeat (2 * SETTLE) @(negedge clk_i);
    if (tracker.errors == 0 && tracker.due_beats.size() == 0) begin
      $display("minmax_pixel_normalizer: match");
    end else begin
      $display("minmax_pixel_normalizer: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mmpn_pkg.sv
rtl/core/minmax_pixel_normalizer.sv
rtl/core/mmpn_checker.sv
sim/minmax_pixel_normalizer_test.sv
